// ===== sv/positional_list_insert_delete_macros.svh =====
// Assertion macros for the positional list block.
`ifndef POSITIONAL_LIST_INSERT_DELETE_MACROS_SVH
`define POSITIONAL_LIST_INSERT_DELETE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PLI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pli_pkg.sv =====
// Shared types and codes for the positional list block.
package pli_pkg;

  localparam logic [1:0] MODE_INS = 2'd0;
  localparam logic [1:0] MODE_DEL = 2'd1;
  localparam logic [1:0] MODE_RD  = 2'd2;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } pli_status_t;

  // Per-cycle command broadcast to every cell, already qualified.
  typedef struct packed {
    logic ins;  // open a gap at the position and write the new value
    logic del;  // close the gap at the position
  } pli_op_t;

endpackage

// ===== sv/pli_if.sv =====
// Valid/ready channel interfaces for requests and results.
interface pli_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [4:0]         position;
  logic signed [31:0] value;

  modport source (output valid, mode, position, value, input ready);
  modport sink   (input valid, mode, position, value, output ready);
endinterface

interface pli_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [4:0]         count_after;
  logic signed [31:0] read_value;

  modport source (output valid, status, count_after, read_value, input ready);
  modport sink   (input valid, status, count_after, read_value, output ready);
endinterface

// ===== sv/positional_list_insert_delete.sv =====
// Positional list top level: request decode, cell chain and result register.
//
// Ordered list of up to DEPTH signed 32-bit entries held in a chain of cells.
// A request inserts a value at a 1-based position (1 to count+1), deletes the
// entry at a position (1 to count) or reads it. On insert or delete the cells
// from the position on load the new value or a neighbour in the same cycle,
// so one request is taken per clock while no result is held back, and its
// result appears in the output register on the next edge; the rate is set
// by the cell update, position compare and read-out select across all cells.
// A new request is taken while a result waits if that result leaves in the
// same cycle. An insert into a full list returns status 2 at any position;
// else a bad position (including zero, or any delete/read on an empty list)
// returns status 1, as does the unused mode; none of these touch the list,
// and read_value is 0 for them and for every insert. count_after is the
// element count after the request, taken to 5 bits. Entries need no
// clearing after reset: only entries below the count are ever read.
module positional_list_insert_delete import pli_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  pli_in_if.sink           in_ch,
  pli_out_if.source        out_ch
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);
  localparam int CW = ((LW > 5) ? LW : 5) + 1;  // room for count + 1

  // Request side
  logic          acc;
  logic [CW-1:0] pos_w;
  logic [CW-1:0] len_w;
  logic          pos_nz;
  logic          full;
  logic          ins_ok;
  logic          del_ok;
  logic          rd_ok;
  logic [4:0]    pos_m1;
  logic [IW-1:0] pos_idx;
  pli_op_t       op;

  // List state
  logic [LW-1:0] len_r;
  logic [LW-1:0] len_nxt;

  // Cell chain
  logic signed [31:0] cell_val [DEPTH];
  logic [DEPTH-1:0]   cell_sel;
  logic signed [31:0] hit_val;

  // Result register
  logic               out_valid_r;
  logic               out_valid_nxt;
  pli_status_t        status_r;
  pli_status_t        status_nxt;
  logic [4:0]         count_r;
  logic signed [31:0] rdv_r;
  logic signed [31:0] rdv_nxt;

  // Output slot frees up when empty or draining this cycle.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;

  assign pos_w  = CW'(in_ch.position);
  assign len_w  = CW'(len_r);
  assign pos_nz = (in_ch.position != 5'd0);
  assign full   = (len_r == LW'(DEPTH));

  assign ins_ok = (in_ch.mode == MODE_INS) && !full && pos_nz
                  && (pos_w <= len_w + CW'(1));
  assign del_ok = (in_ch.mode == MODE_DEL) && pos_nz && (pos_w <= len_w);
  assign rd_ok  = (in_ch.mode == MODE_RD)  && pos_nz && (pos_w <= len_w);

  // Zero-based index; garbage on position zero, but then nothing is qualified.
  assign pos_m1  = in_ch.position - 5'd1;
  assign pos_idx = IW'(pos_m1);

  assign op.ins = acc && ins_ok;
  assign op.del = acc && del_ok;

  // Chain: left is i-1 (input value for cell 0), right is i+1 (last: itself).
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] prev_v;
    logic signed [31:0] next_v;

    if (i == 0) begin : g_first
      assign prev_v = in_ch.value;
    end else begin : g_mid_l
      assign prev_v = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_v = cell_val[i];
    end else begin : g_mid_r
      assign next_v = cell_val[i+1];
    end

    pli_cell #(
      .IW  (IW),
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .op       (op),
      .pos_idx  (pos_idx),
      .new_val  (in_ch.value),
      .prev_val (prev_v),
      .next_val (next_v),
      .val      (cell_val[i]),
      .sel      (cell_sel[i])
    );
  end

  // Read-out: one-hot select from the cells' own position match.
  always_comb begin
    hit_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_val = hit_val | (cell_sel[i] ? cell_val[i] : 32'sd0);
    end
  end

  always_comb begin
    len_nxt = len_r;
    if (op.ins) begin
      len_nxt = len_r + LW'(1);
    end else if (op.del) begin
      len_nxt = len_r - LW'(1);
    end
  end

  always_comb begin
    status_nxt = ST_BADPOS;
    rdv_nxt    = '0;
    if ((in_ch.mode == MODE_INS) && full) begin
      status_nxt = ST_FULL;
    end else if (ins_ok) begin
      status_nxt = ST_OK;
    end else if (del_ok || rd_ok) begin
      status_nxt = ST_OK;
      rdv_nxt    = hit_val;
    end
  end

  assign out_valid_nxt = acc ? 1'b1 : (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, loaded with each accepted transaction.
  always_ff @(posedge clk) begin
    if (acc) begin
      status_r <= status_nxt;
      count_r  <= 5'(len_nxt);
      rdv_r    <= rdv_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.count_after = count_r;
  assign out_ch.read_value  = rdv_r;

`include "positional_list_insert_delete_macros.svh"

  `PLI_ASSERT_NOW(a_len_bound, 1'b1, len_r <= LW'(DEPTH), "count above depth")
  `PLI_ASSERT_NEXT(a_ins_grows, op.ins, len_r == $past(len_r) + LW'(1), "insert lost count")
  `PLI_ASSERT_NOW(a_err_zero, out_valid_r && (status_r != ST_OK), rdv_r == 32'sd0, "error data")
  `PLI_ASSERT_NOW(a_op_excl, 1'b1, !(op.ins && op.del), "insert and delete together")

endmodule

// ===== sv/pli_cell.sv =====
// One list cell: holds an entry and shifts with its neighbours.
module pli_cell import pli_pkg::*; #(
  parameter int IW  = 4,
  parameter int IDX = 0
) (
  input  logic               clk,
  input  pli_op_t            op,
  input  logic [IW-1:0]      pos_idx,
  input  logic signed [31:0] new_val,
  input  logic signed [31:0] prev_val,
  input  logic signed [31:0] next_val,
  output logic signed [31:0] val,
  output logic               sel
);

  logic signed [31:0] val_r;
  logic signed [31:0] val_nxt;
  logic               at_pos;
  logic               past_pos;

  assign at_pos   = (pos_idx == IW'(IDX));
  assign past_pos = (pos_idx <  IW'(IDX));

  always_comb begin
    val_nxt = val_r;
    priority if (op.ins && at_pos) begin
      val_nxt = new_val;
    end else if (op.ins && past_pos) begin
      val_nxt = prev_val;
    end else if (op.del && (at_pos || past_pos)) begin
      val_nxt = next_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;
  assign sel = at_pos;

endmodule
